[design/nearest_vector_scan_defines.svh]
// Assertion macros for the nearest vector scan block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef NEAREST_VECTOR_SCAN_DEFINES_SVH
`define NEAREST_VECTOR_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
`define NVS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NVS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NVS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define NVS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/nvs_pkg.sv]
// Shared constants, codes and types of the nearest vector scan block.
// No dependencies.
package nvs_pkg;

	localparam int MAX_DOCS  = 1024;
	localparam int MAX_DIM   = 128;
	localparam int COMP_BITS = 16;

	localparam int DOC_W    = $clog2(MAX_DOCS);
	localparam int DCNT_W   = DOC_W + 1;
	localparam int POS_W    = $clog2(MAX_DIM);
	localparam int LEN_W    = 8;
	localparam int ADDR_W   = DOC_W + POS_W;
	localparam int DIFF_W   = COMP_BITS + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int DIST_W   = 40;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] CEIL_RESET  = 40'd65535934464;
	localparam logic [LEN_W-1:0]  VLEN_RESET  = 8'd128;

	localparam logic [CFG_IDX_W-1:0] REG_VLEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CEIL = 1'b1;

	localparam logic OP_DOC   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_STORED = 2'd0,
		KIND_ANSWER = 2'd1,
		KIND_FULL   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DOC_W-1:0]   doc_index;
		logic [DIST_W-1:0]  distance;
		logic               found;
	} res_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic query_last;
		logic issue_last;
		logic pipe_busy;
	} status_t;

endpackage

[design/nvs_if.sv]
// Valid/ready channel interfaces for items and results.
// Depends on nvs_pkg.
interface nvs_item_if;
	import nvs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [COMP_BITS-1:0] component;
	modport source (output valid, operation, component, input ready);
	modport sink (input valid, operation, component, output ready);
endinterface

interface nvs_result_if;
	import nvs_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [DOC_W-1:0]  doc_index;
	logic [DIST_W-1:0] distance;
	logic              found;
	modport source (output valid, kind, doc_index, distance, found, input ready);
	modport sink (input valid, kind, doc_index, distance, found, output ready);
endinterface

[design/nvs_ctrl.sv]
// Controller state machine: load, issue scan, drain pipeline, report.
// Depends on nvs_pkg and nearest_vector_scan_defines.svh.
`include "nearest_vector_scan_defines.svh"
module nvs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  logic            skid_full,
	input  nvs_pkg::status_t st,
	output nvs_pkg::cmd_t    cmd
);
	import nvs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ISSUE  = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign item_ready = (state_q == S_IDLE) && !skid_full;
	assign cmd.accept = item_ready && item_valid;
	assign cmd.issue  = (state_q == S_ISSUE);
	assign cmd.report = (state_q == S_REPORT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept && st.query_last) state_d = S_ISSUE;
			end
			S_ISSUE: begin
				if (st.issue_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!st.pipe_busy) state_d = S_REPORT;
			end
			S_REPORT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`NVS_ASSERT_NXT(a_scan_starts, clk, arst_n, cmd.accept && st.query_last, state_q == S_ISSUE, "last query transfer did not start a scan")
	`NVS_ASSERT_IMP(a_report_drained, clk, arst_n, state_q == S_REPORT, !st.pipe_busy, "report while scan pipeline busy")
	`NVS_ASSERT_NXT(a_report_once, clk, arst_n, state_q == S_REPORT, state_q == S_IDLE, "report held longer than one cycle")

endmodule

[design/nvs_datapath.sv]
// Datapath: config registers, vector stores, scan pipeline and best tracker.
// Depends on nvs_pkg.
module nvs_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nvs_pkg::cmd_t                   cmd,
	output nvs_pkg::status_t                st,
	input  logic                            operation,
	input  logic [nvs_pkg::COMP_BITS-1:0]   component,
	input  logic                            cfg_wr_en,
	input  logic [nvs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nvs_pkg::DIST_W-1:0]      cfg_data,
	output logic                            push,
	output nvs_pkg::res_t                   res
);
	import nvs_pkg::*;

	logic [LEN_W-1:0]     vlen_q;
	logic [DIST_W-1:0]    ceil_q;
	logic [DCNT_W-1:0]    doc_cnt_q;
	logic [POS_W-1:0]     dcomp_q;
	logic [POS_W-1:0]     qcomp_q;

	logic [COMP_BITS-1:0] doc_mem [(MAX_DOCS * MAX_DIM)];
	logic [COMP_BITS-1:0] qry_mem [MAX_DIM];

	logic [LEN_W-1:0]     len;
	logic                 store_full;
	logic                 doc_last;
	logic                 acc_doc;
	logic                 acc_qry;
	logic                 empty;
	logic                 issue_valid;
	logic                 comp_last;
	logic                 docs_last;

	logic [DOC_W-1:0]     doc_idx_q;
	logic [POS_W-1:0]     comp_idx_q;

	logic                 valid_s1, first_s1, last_s1;
	logic [DOC_W-1:0]     doc_s1;
	logic [COMP_BITS-1:0] dval_s1, qval_s1;

	logic                 valid_s2, first_s2, last_s2;
	logic [DOC_W-1:0]     doc_s2;
	logic [SQ_W-1:0]      sq_s2;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SQ_W-1:0]   prod;

	logic                 done_s3;
	logic [DOC_W-1:0]     doc_s3;
	logic [DIST_W-1:0]    acc_s3;
	logic [DIST_W:0]      acc_sum;

	logic [DIST_W-1:0]    best_q;
	logic [DOC_W-1:0]     best_idx_q;
	logic                 found_q;

	always_comb begin
		if (vlen_q == '0) begin
			len = LEN_W'(1);
		end else if (vlen_q > LEN_W'(MAX_DIM)) begin
			len = LEN_W'(MAX_DIM);
		end else begin
			len = vlen_q;
		end
	end

	assign store_full = (doc_cnt_q >= DCNT_W'(MAX_DOCS));
	assign acc_doc    = cmd.accept && (operation == OP_DOC);
	assign acc_qry    = cmd.accept && (operation == OP_QUERY);
	assign doc_last   = (LEN_W'(dcomp_q) + LEN_W'(1)) >= len;
	assign st.query_last = (operation == OP_QUERY) && ((LEN_W'(qcomp_q) + LEN_W'(1)) >= len);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VLEN_RESET;
			ceil_q <= CEIL_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VLEN: vlen_q <= cfg_data[LEN_W-1:0];
				REG_CEIL: ceil_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// load counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_cnt_q <= '0;
			dcomp_q   <= '0;
			qcomp_q   <= '0;
		end else begin
			if (acc_doc) begin
				if (doc_last) begin
					dcomp_q <= '0;
					if (!store_full) doc_cnt_q <= doc_cnt_q + DCNT_W'(1);
				end else begin
					dcomp_q <= dcomp_q + POS_W'(1);
				end
			end
			if (acc_qry) begin
				if (st.query_last) begin
					qcomp_q <= '0;
				end else begin
					qcomp_q <= qcomp_q + POS_W'(1);
				end
			end
		end
	end

	// scan address generation
	assign empty       = (doc_cnt_q == '0);
	assign issue_valid = cmd.issue && !empty;
	assign comp_last   = (LEN_W'(comp_idx_q) == (len - LEN_W'(1)));
	assign docs_last   = ({1'b0, doc_idx_q} == (doc_cnt_q - DCNT_W'(1)));
	assign st.issue_last = empty || (comp_last && docs_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_idx_q  <= '0;
			comp_idx_q <= '0;
		end else if (acc_qry && st.query_last) begin
			doc_idx_q  <= '0;
			comp_idx_q <= '0;
		end else if (issue_valid) begin
			if (comp_last) begin
				comp_idx_q <= '0;
				doc_idx_q  <= doc_idx_q + DOC_W'(1);
			end else begin
				comp_idx_q <= comp_idx_q + POS_W'(1);
			end
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (acc_doc && !store_full) begin
			doc_mem[{doc_cnt_q[DOC_W-1:0], dcomp_q}] <= component;
		end
		dval_s1 <= doc_mem[{doc_idx_q, comp_idx_q}];
	end

	always_ff @(posedge clk) begin
		if (acc_qry) begin
			qry_mem[qcomp_q] <= component;
		end
		qval_s1 <= qry_mem[comp_idx_q];
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			valid_s1 <= issue_valid;
			valid_s2 <= valid_s1;
			done_s3  <= valid_s2 && last_s2;
		end
	end

	assign st.pipe_busy = valid_s1 || valid_s2 || done_s3;

	// square of difference
	assign diff = $signed({qval_s1[COMP_BITS-1], qval_s1}) - $signed({dval_s1[COMP_BITS-1], dval_s1});
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		first_s1 <= (comp_idx_q == '0);
		last_s1  <= comp_last;
		doc_s1   <= doc_idx_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		doc_s2   <= doc_s1;
		sq_s2    <= $unsigned(prod);
		doc_s3   <= doc_s2;
	end

	// saturating accumulation
	assign acc_sum = {1'b0, acc_s3} + (DIST_W + 1)'(sq_s2);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (first_s2) begin
				acc_s3 <= DIST_W'(sq_s2);
			end else if (acc_sum[DIST_W]) begin
				acc_s3 <= DIST_MAX;
			end else begin
				acc_s3 <= acc_sum[DIST_W-1:0];
			end
		end
	end

	// best tracker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (acc_qry && st.query_last) begin
			best_q     <= ceil_q;
			best_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (done_s3 && (acc_s3 < best_q)) begin
			best_q     <= acc_s3;
			best_idx_q <= doc_s3;
			found_q    <= 1'b1;
		end
	end

	// result
	assign push = (acc_doc && doc_last) || cmd.report;

	always_comb begin
		res = '0;
		priority if (cmd.report) begin
			res.kind      = KIND_ANSWER;
			res.doc_index = best_idx_q;
			res.distance  = best_q;
			res.found     = found_q;
		end else if (store_full) begin
			res.kind      = KIND_FULL;
		end else begin
			res.kind      = KIND_STORED;
			res.doc_index = doc_cnt_q[DOC_W-1:0];
		end
	end

endmodule

[design/nvs_outbuf.sv]
// Two-entry result buffer (output register plus skid) driving the result channel.
// Depends on nvs_pkg, nvs_if and nearest_vector_scan_defines.svh.
`include "nearest_vector_scan_defines.svh"
module nvs_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nvs_pkg::res_t  res,
	output logic           skid_full,
	nvs_result_if.source   result
);
	import nvs_pkg::*;

	logic head_valid_q, skid_valid_q;
	res_t head_q, skid_q;
	logic pop, head_free;

	assign pop       = head_valid_q && result.ready;
	assign head_free = !head_valid_q || pop;
	assign skid_full = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			head_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			head_q <= skid_valid_q ? skid_q : res;
			if (push) skid_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign result.valid     = head_valid_q;
	assign result.kind      = head_q.kind;
	assign result.doc_index = head_q.doc_index;
	assign result.distance  = head_q.distance;
	assign result.found     = head_q.found;

	`NVS_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !skid_valid_q, "result pushed into full buffer")

endmodule

[design/nearest_vector_scan.sv]
// Top level: one transfer per cycle while loading and results are taken; a document or
// partial query transfer has its result (if any) registered in the result buffer.
// A last query component starts a scan of every stored document over vector_length
// components (one store read per cycle, none for an empty store), then drain and report;
// no transfer is taken meanwhile. Reset: counters cleared, vector_length 128, ceiling
// 999999.0, stores not cleared. Depends on nvs_pkg, nvs_if, nvs_ctrl, nvs_datapath, nvs_outbuf.
module nearest_vector_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	nvs_item_if.sink                       item,
	nvs_result_if.source                   result,
	input  logic                           cfg_wr_en,
	input  logic [nvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nvs_pkg::DIST_W-1:0]     cfg_data
);
	import nvs_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    push;
	res_t    res;
	logic    skid_full;

	nvs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.skid_full  (skid_full),
		.st         (st),
		.cmd        (cmd)
	);

	nvs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.operation (item.operation),
		.component (item.component),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.res       (res)
	);

	nvs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.skid_full (skid_full),
		.result    (result)
	);

endmodule
